// ----- rtl/mfmt_pkg.sv -----
`default_nettype none
package mfmt_pkg;

  localparam int unsigned GROUP_SIZE = 3;
  localparam int unsigned SLOT_COUNT = 6;
  localparam int unsigned SCALE_SHIFT = 13;

  localparam logic signed [16:0] WRAP_LIMIT = 17'sd6000;
  localparam logic signed [15:0] TURNS_MAX = 16'sh7fff;
  localparam logic signed [15:0] TURNS_MIN = 16'sh8000;

  localparam logic [1:0] REG_LOW_BASE  = 2'd0;
  localparam logic [1:0] REG_HIGH_BASE = 2'd1;
  localparam logic [1:0] REG_LAST_ID   = 2'd2;

  localparam logic [10:0] LOW_BASE_RESET  = 11'd513;
  localparam logic [10:0] HIGH_BASE_RESET = 11'd517;
  localparam logic [10:0] LAST_ID_RESET   = 11'd519;

  typedef struct packed {
    logic [10:0] low_base;
    logic [10:0] high_base;
    logic [10:0] last_id;
  } mfmt_cfg_t;

  typedef struct packed {
    logic [2:0]         slot;
    logic               high;
    logic [15:0]        angle;
    logic signed [15:0] speed;
    logic signed [15:0] torque;
    logic [7:0]         temperature;
  } mfmt_req_t;

endpackage
`default_nettype wire

// ----- rtl/mfmt_front.sv -----
`default_nettype none
module mfmt_front (
  input  wire logic              frame_valid,
  output logic                   frame_stall,
  input  wire logic [10:0]       frame_id,
  input  wire logic [7:0]        byte_zero,
  input  wire logic [7:0]        byte_one,
  input  wire logic [7:0]        byte_two,
  input  wire logic [7:0]        byte_three,
  input  wire logic [7:0]        byte_four,
  input  wire logic [7:0]        byte_five,
  input  wire logic [7:0]        byte_six,
  input  wire mfmt_pkg::mfmt_cfg_t cfg,
  input  wire logic              q_full,
  output logic                   push,
  output mfmt_pkg::mfmt_req_t    req
);

  logic [10:0] low_off;
  logic [10:0] high_off;
  logic        in_window;
  logic        low_hit;
  logic        high_hit;

  assign low_off   = frame_id - cfg.low_base;
  assign high_off  = frame_id - cfg.high_base;
  assign in_window = (frame_id >= cfg.low_base) && (frame_id <= cfg.last_id);
  assign low_hit   = low_off < 11'(mfmt_pkg::GROUP_SIZE);
  assign high_hit  = (frame_id >= cfg.high_base) && (high_off < 11'(mfmt_pkg::GROUP_SIZE));

  assign frame_stall = q_full;
  // drop frames with no slot at the door
  assign push = frame_valid && !q_full && in_window && (low_hit || high_hit);

  always_comb begin
    req.high        = !low_hit;
    req.slot        = low_hit ? low_off[2:0]
                              : 3'(mfmt_pkg::GROUP_SIZE) + high_off[2:0];
    req.angle       = {byte_zero, byte_one};
    req.speed       = {byte_two, byte_three};
    req.torque      = {byte_four, byte_five};
    req.temperature = low_hit ? 8'd0 : byte_six;
  end

endmodule
`default_nettype wire

// ----- rtl/mfmt_queue.sv -----
`default_nettype none
module mfmt_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire mfmt_pkg::mfmt_req_t push_req,
  output logic                     full,
  input  wire logic                pop,
  output logic                     head_valid,
  output mfmt_pkg::mfmt_req_t      head_req
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mfmt_pkg::mfmt_req_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_req   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mfmt_back.sv -----
`default_nettype none
module mfmt_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                head_valid,
  input  wire mfmt_pkg::mfmt_req_t head_req,
  output logic                     pop,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic [2:0]               slot,
  output logic [15:0]              angle,
  output logic signed [15:0]       speed,
  output logic signed [15:0]       torque_or_current,
  output logic [7:0]               temperature,
  output logic signed [15:0]       turns,
  output logic signed [29:0]       total_angle,
  output logic [31:0]              frame_count
);

  logic [15:0]        prev_angle [mfmt_pkg::SLOT_COUNT];
  logic signed [15:0] turn_cnt   [mfmt_pkg::SLOT_COUNT];
  logic [31:0]        frames     [mfmt_pkg::SLOT_COUNT];

  // update stage
  logic                s1_valid;
  mfmt_pkg::mfmt_req_t s1_req;
  logic signed [15:0]  s1_turns;
  logic [31:0]         s1_count;

  logic                s1_load;
  logic                s2_load;
  logic signed [16:0]  delta;
  logic signed [15:0]  turns_next;
  logic [31:0]         count_next;
  logic signed [29:0]  turns_wide;
  logic signed [29:0]  total_next;

  assign s2_load = !result_valid || !result_stall;
  assign s1_load = !s1_valid || s2_load;
  assign pop     = head_valid && s1_load;

  always_comb begin
    delta = $signed({1'b0, head_req.angle}) - $signed({1'b0, prev_angle[head_req.slot]});
    turns_next = turn_cnt[head_req.slot];
    // a jump of more than the limit is an encoder wrap
    if (delta < -mfmt_pkg::WRAP_LIMIT && turns_next != mfmt_pkg::TURNS_MAX) begin
      turns_next = turns_next + 16'sd1;
    end else if (delta > mfmt_pkg::WRAP_LIMIT && turns_next != mfmt_pkg::TURNS_MIN) begin
      turns_next = turns_next - 16'sd1;
    end
    count_next = frames[head_req.slot] + 32'd1;
  end

  always_comb begin
    turns_wide = 30'(s1_turns);
    // high group scales by 8192, low group by 8191
    total_next = $signed({14'd0, s1_req.angle}) + (turns_wide <<< mfmt_pkg::SCALE_SHIFT)
               - (s1_req.high ? 30'sd0 : turns_wide);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mfmt_pkg::SLOT_COUNT; i++) begin
        prev_angle[i] <= '0;
        turn_cnt[i]   <= '0;
        frames[i]     <= '0;
      end
    end else if (pop) begin
      prev_angle[head_req.slot] <= head_req.angle;
      turn_cnt[head_req.slot]   <= turns_next;
      frames[head_req.slot]     <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= pop;
      end
      if (s2_load) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_req   <= head_req;
      s1_turns <= turns_next;
      s1_count <= count_next;
    end
    if (s2_load && s1_valid) begin
      slot              <= s1_req.slot;
      angle             <= s1_req.angle;
      speed             <= s1_req.speed;
      torque_or_current <= s1_req.torque;
      temperature       <= s1_req.temperature;
      turns             <= s1_turns;
      total_angle       <= total_next;
      frame_count       <= s1_count;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/motor_feedback_multiturn_tracker_top.sv -----
`default_nettype none
// Multi-turn angle tracker for motor feedback frames. Each frame (identifier and
// seven payload bytes) is checked against the identifier window, mapped to one
// of six motor slots and queued; the back end then updates that slot's turn
// count and frame count and reports angle, speed, torque or current,
// temperature, turns and total angle. Frames with no slot give no result. The
// block takes one frame per clock and a taken frame passes through its queue
// entry, the slot state update and the total angle stage in turn; the front
// stalls only when the QUEUE_DEPTH-entry queue is full, which happens when the
// result side holds off. Registers: 0x0 low group base, 0x4 high group base,
// 0x8 last accepted identifier; write them only while the block is idle.
module motor_feedback_multiturn_tracker_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              frame_valid,
  output logic                   frame_stall,
  input  wire logic [10:0]       frame_id,
  input  wire logic [7:0]        byte_zero,
  input  wire logic [7:0]        byte_one,
  input  wire logic [7:0]        byte_two,
  input  wire logic [7:0]        byte_three,
  input  wire logic [7:0]        byte_four,
  input  wire logic [7:0]        byte_five,
  input  wire logic [7:0]        byte_six,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [2:0]             slot,
  output logic [15:0]            angle,
  output logic signed [15:0]     speed,
  output logic signed [15:0]     torque_or_current,
  output logic [7:0]             temperature,
  output logic signed [15:0]     turns,
  output logic signed [29:0]     total_angle,
  output logic [31:0]            frame_count
);

  mfmt_pkg::mfmt_cfg_t cfg;
  mfmt_pkg::mfmt_req_t push_req;
  mfmt_pkg::mfmt_req_t head_req;
  logic                push;
  logic                q_full;
  logic                head_valid;
  logic                pop;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_base  <= mfmt_pkg::LOW_BASE_RESET;
      cfg.high_base <= mfmt_pkg::HIGH_BASE_RESET;
      cfg.last_id   <= mfmt_pkg::LAST_ID_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        mfmt_pkg::REG_LOW_BASE:  cfg.low_base  <= pwdata[10:0];
        mfmt_pkg::REG_HIGH_BASE: cfg.high_base <= pwdata[10:0];
        mfmt_pkg::REG_LAST_ID:   cfg.last_id   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mfmt_pkg::REG_LOW_BASE:  prdata = {21'd0, cfg.low_base};
      mfmt_pkg::REG_HIGH_BASE: prdata = {21'd0, cfg.high_base};
      mfmt_pkg::REG_LAST_ID:   prdata = {21'd0, cfg.last_id};
      default:                 prdata = 32'd0;
    endcase
  end

  mfmt_front u_front (
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_id    (frame_id),
    .byte_zero   (byte_zero),
    .byte_one    (byte_one),
    .byte_two    (byte_two),
    .byte_three  (byte_three),
    .byte_four   (byte_four),
    .byte_five   (byte_five),
    .byte_six    (byte_six),
    .cfg         (cfg),
    .q_full      (q_full),
    .push        (push),
    .req         (push_req)
  );

  mfmt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_req   (push_req),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  mfmt_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head_valid        (head_valid),
    .head_req          (head_req),
    .pop               (pop),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .slot              (slot),
    .angle             (angle),
    .speed             (speed),
    .torque_or_current (torque_or_current),
    .temperature       (temperature),
    .turns             (turns),
    .total_angle       (total_angle),
    .frame_count       (frame_count)
  );

endmodule
`default_nettype wire

// ----- rtl/mfmt_checker.sv -----
`default_nettype none
module mfmt_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire logic [2:0]        slot,
  input wire logic [15:0]       angle,
  input wire logic [7:0]        temperature,
  input wire logic signed [29:0] total_angle,
  input wire logic [31:0]       frame_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(total_angle)
      && $stable(frame_count))
    else $error("stalled result changed");

  a_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> slot < 3'd6)
    else $error("result slot out of range");

  a_low_temp: assert property (@(posedge clk) disable iff (rst)
    result_valid && slot < 3'd3 |-> temperature == 8'd0)
    else $error("low group temperature not zero");

  a_high_total: assert property (@(posedge clk) disable iff (rst)
    result_valid && slot >= 3'd3 |-> total_angle[12:0] == angle[12:0])
    else $error("high group total angle mismatch");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind motor_feedback_multiturn_tracker_top mfmt_checker u_mfmt_checker (.*);
`default_nettype wire
